// ===== sv/multi_queue_fifo_bank_macros.svh =====
// ----------------------------------------------------------------------------
// multi_queue_fifo_bank assertion macros
// clocked assertions on clk, with and without the reset qualifier
// ----------------------------------------------------------------------------
`ifndef MULTI_QUEUE_FIFO_BANK_MACROS_SVH
`define MULTI_QUEUE_FIFO_BANK_MACROS_SVH

// checked only while out of reset
`define MQFB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define MQFB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/mqfb_pkg.sv =====
// ----------------------------------------------------------------------------
// mqfb_pkg
// shared types, codes and defaults of the multi-queue fifo bank
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mqfb_pkg;

  localparam int NUM_QUEUES_DEF  = 4;
  localparam int QUEUE_SLOTS_DEF = 16;

  localparam int CMD_DEPTH = 2;
  localparam int OUT_DEPTH = 4;

  localparam logic [15:0] LOST_MAX = 16'hFFFF;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_BAD_INDEX = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_WRITE,
    OP_READ,
    OP_NOP,
    OP_BAD
  } op_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [2:0]         queue_index;
    logic signed [31:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_data;
    logic [15:0]        lost_count;
    logic [3:0]         occupancy;
  } out_item_t;

  typedef struct packed {
    op_t                op;
    logic [2:0]         qidx;
    logic signed [31:0] data;
  } cmd_t;

endpackage

// ===== sv/mqfb_fifo.sv =====
// ----------------------------------------------------------------------------
// mqfb_fifo
// small register fifo with fill level, used for command and result queues
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mqfb_fifo
  import mqfb_pkg::*;
#(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [W-1:0]               din,
  output logic                       full,
  input  logic                       pop,
  output logic [W-1:0]               dout,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);

  logic [W-1:0]  data_r [DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt;
  logic [PW-1:0] rptr_r, rptr_nxt;
  logic [LW-1:0] level_r, level_nxt;
  logic          do_push, do_pop;

  assign full    = (level_r == LW'(DEPTH));
  assign empty   = (level_r == '0);
  assign level   = level_r;
  assign dout    = data_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    level_nxt = level_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      level_nxt = level_r + 1'b1;
    end else if (do_pop && !do_push) begin
      level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      level_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      data_r[wptr_r] <= din;
    end
  end

endmodule

// ===== sv/mqfb_front.sv =====
// ----------------------------------------------------------------------------
// mqfb_front
// classifies an incoming item into a queue command, flagging bad indexes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mqfb_front
  import mqfb_pkg::*;
#(
  parameter int NUM_QUEUES = NUM_QUEUES_DEF
) (
  input  in_item_t item,
  output cmd_t     cmd
);

  always_comb begin
    cmd.qidx = item.queue_index;
    cmd.data = item.write_data;
    if (32'(item.queue_index) >= NUM_QUEUES) begin
      cmd.op = OP_BAD;
    end else begin
      unique case (item.action)
        ACT_CLEAR: cmd.op = OP_CLEAR;
        ACT_WRITE: cmd.op = OP_WRITE;
        ACT_READ:  cmd.op = OP_READ;
        ACT_NONE:  cmd.op = OP_NOP;
        default:   cmd.op = OP_NOP;
      endcase
    end
  end

endmodule

// ===== sv/mqfb_back.sv =====
// ----------------------------------------------------------------------------
// mqfb_back
// executes queue commands: pointer and counter update, slot memory access,
// result formation in the following cycle with the registered read word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mqfb_back
  import mqfb_pkg::*;
#(
  parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
  parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cmd_empty,
  input  cmd_t                           cmd_item,
  output logic                           cmd_pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0] out_level,
  output logic                           out_push,
  output out_item_t                      out_item
);

  localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PW    = $clog2(QUEUE_SLOTS);
  localparam int WORDS = NUM_QUEUES * QUEUE_SLOTS;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

  logic [PW-1:0]      head_r [NUM_QUEUES];
  logic [PW-1:0]      head_nxt [NUM_QUEUES];
  logic [PW-1:0]      tail_r [NUM_QUEUES];
  logic [PW-1:0]      tail_nxt [NUM_QUEUES];
  logic [PW-1:0]      cnt_r [NUM_QUEUES];
  logic [PW-1:0]      cnt_nxt [NUM_QUEUES];
  logic [15:0]        lost_r [NUM_QUEUES];
  logic [15:0]        lost_nxt [NUM_QUEUES];

  logic signed [31:0] slot_mem_r [WORDS];
  logic signed [31:0] mem_q_r;

  logic               s2_valid_r;
  logic [1:0]         s2_status_r;
  logic [15:0]        s2_lost_r;
  logic [3:0]         s2_occ_r;
  logic               s2_rd_r;

  logic [QW-1:0]      q;
  logic               issue;
  logic               wr_en, rd_en;
  logic [AW-1:0]      waddr, raddr;
  logic [1:0]         status;
  logic [15:0]        lost_o;
  logic [3:0]         occ_o;

  assign q       = QW'(cmd_item.qidx);
  assign issue   = !cmd_empty && ((int'(out_level) + int'(s2_valid_r)) < OUT_DEPTH);
  assign cmd_pop = issue;
  assign waddr   = AW'(q) * AW'(QUEUE_SLOTS) + AW'(tail_r[q]);
  assign raddr   = AW'(q) * AW'(QUEUE_SLOTS) + AW'(head_r[q]);

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    lost_nxt = lost_r;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    status   = ST_OK;
    if (issue) begin
      unique case (cmd_item.op)
        OP_CLEAR: begin
          head_nxt[q] = '0;
          tail_nxt[q] = '0;
          cnt_nxt[q]  = '0;
          lost_nxt[q] = '0;
        end
        OP_WRITE: begin
          if (cnt_r[q] >= PW'(QUEUE_SLOTS - 1)) begin
            status = ST_FULL;
            if (lost_r[q] != LOST_MAX) begin
              lost_nxt[q] = lost_r[q] + 16'd1;
            end
          end else begin
            wr_en       = 1'b1;
            tail_nxt[q] = (tail_r[q] == PW'(QUEUE_SLOTS - 1)) ? '0 : tail_r[q] + 1'b1;
            cnt_nxt[q]  = cnt_r[q] + 1'b1;
          end
        end
        OP_READ: begin
          if (cnt_r[q] == '0) begin
            status = ST_EMPTY;
          end else begin
            rd_en       = 1'b1;
            head_nxt[q] = (head_r[q] == PW'(QUEUE_SLOTS - 1)) ? '0 : head_r[q] + 1'b1;
            cnt_nxt[q]  = cnt_r[q] - 1'b1;
          end
        end
        OP_BAD:  status = ST_BAD_INDEX;
        OP_NOP:  status = ST_OK;
        default: status = ST_OK;
      endcase
    end
    if (cmd_item.op == OP_BAD) begin
      lost_o = '0;
      occ_o  = '0;
    end else begin
      lost_o = lost_nxt[q];
      occ_o  = 4'(cnt_nxt[q]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i]  <= '0;
        lost_r[i] <= '0;
      end
      s2_valid_r <= 1'b0;
    end else begin
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      cnt_r      <= cnt_nxt;
      lost_r     <= lost_nxt;
      s2_valid_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s2_status_r <= status;
      s2_lost_r   <= lost_o;
      s2_occ_r    <= occ_o;
      s2_rd_r     <= rd_en;
    end
  end

  // slot memory, one write and one read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem_r[waddr] <= cmd_item.data;
    end
    if (rd_en) begin
      mem_q_r <= slot_mem_r[raddr];
    end
  end

  assign out_push           = s2_valid_r;
  assign out_item.status     = s2_status_r;
  assign out_item.read_data  = s2_rd_r ? mem_q_r : 32'sd0;
  assign out_item.lost_count = s2_lost_r;
  assign out_item.occupancy  = s2_occ_r;

endmodule

// ===== sv/multi_queue_fifo_bank.sv =====
// Bank of NUM_QUEUES circular word queues with QUEUE_SLOTS slots each.
// Input channel: in_push / in_full carry an item (action, queue_index,
// write_data) that clears, writes or reads one queue. A queue is full at
// QUEUE_SLOTS-1 entries; writes to a full queue are dropped and counted.
// Result channel: out_empty / out_pop present one result per item, in item
// order: status, popped word, lost-data count and occupancy of the queue.
// A result becomes poppable once its item has passed the command queue, the
// execute stage with its registered slot read, and the result queue.
// Throughput: one item per cycle while results are popped; execution
// updates one queue's pointers and does one slot memory access per cycle.
// The command queue (2 deep) lets the input keep flowing briefly while the
// execute stage waits; the result queue (4 deep) holds finished results.
// When the receiver stalls, the result queue fills, execution pauses, then
// the command queue fills and in_full rises; nothing is lost.
// Reset (rst_n low, synchronous) empties both queues and zeroes all queue
// pointers, counts and lost-data counters; slot contents are not cleared.
// ----------------------------------------------------------------------------
// multi_queue_fifo_bank
// top level: front classifier, command queue, execute stage, result queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_queue_fifo_bank
  import mqfb_pkg::*;
#(
  parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
  parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_item,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  localparam int CW = $bits(cmd_t);
  localparam int OW = $bits(out_item_t);
  localparam int CLW = $clog2(CMD_DEPTH + 1);
  localparam int OLW = $clog2(OUT_DEPTH + 1);

  cmd_t            front_cmd;
  cmd_t            back_cmd;
  logic [CW-1:0]   cmd_dout;
  logic            cmd_empty;
  logic            cmd_pop;
  logic [CLW-1:0]  cmd_level;
  logic            res_push;
  out_item_t       res_item;
  logic [OW-1:0]   res_dout;
  logic            res_full;
  logic [OLW-1:0]  res_level;

  mqfb_front #(
    .NUM_QUEUES(NUM_QUEUES)
  ) u_front (
    .item (in_item),
    .cmd  (front_cmd)
  );

  mqfb_fifo #(
    .W    (CW),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (in_push),
    .din  (front_cmd),
    .full (in_full),
    .pop  (cmd_pop),
    .dout (cmd_dout),
    .empty(cmd_empty),
    .level(cmd_level)
  );

  assign back_cmd = cmd_t'(cmd_dout);

  mqfb_back #(
    .NUM_QUEUES (NUM_QUEUES),
    .QUEUE_SLOTS(QUEUE_SLOTS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_empty(cmd_empty),
    .cmd_item (back_cmd),
    .cmd_pop  (cmd_pop),
    .out_level(res_level),
    .out_push (res_push),
    .out_item (res_item)
  );

  mqfb_fifo #(
    .W    (OW),
    .DEPTH(OUT_DEPTH)
  ) u_out_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_push),
    .din  (res_item),
    .full (res_full),
    .pop  (out_pop),
    .dout (res_dout),
    .empty(out_empty),
    .level(res_level)
  );

  assign out_item = out_item_t'(res_dout);

  // result queue never overflows: execution is credit limited
  logic unused_ok;
  assign unused_ok = res_full & (cmd_level != '0);

endmodule

// ===== sv/mqfb_checker.sv =====
// ----------------------------------------------------------------------------
// mqfb_checker
// port-level checks of the multi-queue fifo bank, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "multi_queue_fifo_bank_macros.svh"

module mqfb_checker
  import mqfb_pkg::*;
#(
  parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  input logic      in_push,
  input logic      in_full,
  input in_item_t  in_item,
  input logic      out_empty,
  input logic      out_pop,
  input out_item_t out_item
);

  `MQFB_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> out_empty && !in_full, "reset did not empty")
  `MQFB_ASSERT(a_result_holds, !out_empty && !out_pop |=> !out_empty && $stable(out_item), "stalled item changed")
  `MQFB_ASSERT(a_bad_index_zero, !out_empty && out_item.status == ST_BAD_INDEX |-> out_item.read_data == 0 && out_item.lost_count == 0 && out_item.occupancy == 0, "bad index item has nonzero fields")
  `MQFB_ASSERT(a_full_occ, !out_empty && out_item.status == ST_FULL |-> out_item.occupancy == 4'(QUEUE_SLOTS - 1) && out_item.read_data == 0 && out_item.lost_count != 0, "full item inconsistent")
  `MQFB_ASSERT(a_empty_occ, !out_empty && out_item.status == ST_EMPTY |-> out_item.occupancy == 0 && out_item.read_data == 0, "empty item inconsistent")

endmodule

bind multi_queue_fifo_bank mqfb_checker #(
  .QUEUE_SLOTS(QUEUE_SLOTS)
) u_mqfb_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_push  (in_push),
  .in_full  (in_full),
  .in_item  (in_item),
  .out_empty(out_empty),
  .out_pop  (out_pop),
  .out_item (out_item)
);

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking testbench of the multi-queue fifo bank: directed clear, write
// and read items on the queues, full and empty queues, bad indexes, lost-data
// counting, then random item streams with bursty push and pop, every result
// compared field by field against an in-bench model of the four queues
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import mqfb_pkg::*;

  localparam int NQ          = NUM_QUEUES_DEF;
  localparam int NS          = QUEUE_SLOTS_DEF;
  localparam int CYCLE_LIMIT = 600000;
  localparam int LOST_WRITES = 40;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_push = 1'b0;
  logic      in_full;
  in_item_t  in_item = '0;
  logic      out_empty;
  logic      out_pop = 1'b0;
  out_item_t out_item;

  multi_queue_fifo_bank u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  // model of the queue bank
  logic signed [31:0] q_slots [NQ][NS];
  int                 q_head  [NQ];
  int                 q_tail  [NQ];
  int                 q_count [NQ];
  logic [15:0]        q_lost  [NQ];

  out_item_t pending_results[$];

  int  err_count   = 0;
  int  items_sent  = 0;
  int  results_ok  = 0;
  int  full_seen   = 0;
  int  empty_seen  = 0;
  int  bad_seen    = 0;
  int  cycles      = 0;
  bit  idle_on     = 1'b0;
  bit  stall_on    = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: timeout after %0d cycles", cycles);
      $display("tb_top: done, errors");
      $finish;
    end
  end

  function automatic out_item_t bank_predict(in_item_t it);
    out_item_t r;
    int        q;
    r = '0;
    if (it.queue_index >= NQ) begin
      r.status = ST_BAD_INDEX;
      return r;
    end
    q = it.queue_index;
    case (it.action)
      ACT_CLEAR: begin
        q_head[q]  = 0;
        q_tail[q]  = 0;
        q_count[q] = 0;
        q_lost[q]  = '0;
      end
      ACT_WRITE: begin
        if (q_count[q] >= NS - 1) begin
          if (q_lost[q] != LOST_MAX) q_lost[q] = q_lost[q] + 16'd1;
          r.status = ST_FULL;
        end else begin
          q_slots[q][q_tail[q]] = it.write_data;
          q_tail[q]  = (q_tail[q] == NS - 1) ? 0 : q_tail[q] + 1;
          q_count[q] = q_count[q] + 1;
        end
      end
      ACT_READ: begin
        if (q_count[q] == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.read_data = q_slots[q][q_head[q]];
          q_head[q]  = (q_head[q] == NS - 1) ? 0 : q_head[q] + 1;
          q_count[q] = q_count[q] - 1;
        end
      end
      default: ;
    endcase
    r.lost_count = q_lost[q];
    r.occupancy  = 4'(q_count[q]);
    return r;
  endfunction

  function automatic in_item_t mk_item(logic [1:0] act, logic [2:0] idx,
                                       logic signed [31:0] data);
    in_item_t it;
    it.action      = act;
    it.queue_index = idx;
    it.write_data  = data;
    return it;
  endfunction

  // push stays high across back-to-back items
  task automatic send_item(input in_item_t it);
    int        gap;
    out_item_t exp_r;
    gap = (idle_on && $urandom_range(0, 7) == 0) ? $urandom_range(1, 17) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push <= 1'b1;
    in_item <= it;
    forever begin
      @(posedge clk);
      if (!in_full) break;
    end
    exp_r = bank_predict(it);
    pending_results.push_back(exp_r);
    items_sent++;
    case (exp_r.status)
      ST_FULL:      full_seen++;
      ST_EMPTY:     empty_seen++;
      ST_BAD_INDEX: bad_seen++;
      default: ;
    endcase
  endtask

  task automatic send_op(input logic [1:0] act, input logic [2:0] idx,
                         input logic signed [31:0] data);
    send_item(mk_item(act, idx, data));
  endtask

  task automatic stop_push();
    @(negedge clk);
    in_push <= 1'b0;
  endtask

  task automatic wait_all_results();
    stop_push();
    forever begin
      @(posedge clk);
      if (pending_results.size() == 0) break;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d read_data %0d lost_count %0d occupancy %0d",
               out_item.status, out_item.read_data, out_item.lost_count,
               out_item.occupancy);
        err_count++;
      end else begin
        e = pending_results.pop_front();
        if (out_item.status !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, out_item.status);
          err_count++;
        end
        if (out_item.read_data !== e.read_data) begin
          $error("read_data: expected %0d, actual %0d", e.read_data, out_item.read_data);
          err_count++;
        end
        if (out_item.lost_count !== e.lost_count) begin
          $error("lost_count: expected %0d, actual %0d", e.lost_count, out_item.lost_count);
          err_count++;
        end
        if (out_item.occupancy !== e.occupancy) begin
          $error("occupancy: expected %0d, actual %0d", e.occupancy, out_item.occupancy);
          err_count++;
        end
        results_ok++;
      end
    end
  end

  // receiver with random stall bursts
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (stall_on && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 17);
        out_pop <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  task automatic test_basic_ops();
    send_op(ACT_READ,  3'd0, 32'sd0);
    send_op(ACT_WRITE, 3'd0, 32'sh7FFFFFFF);
    send_op(ACT_WRITE, 3'd0, 32'sh80000000);
    send_op(ACT_WRITE, 3'd0, 32'sd0);
    send_op(ACT_WRITE, 3'd0, -32'sd1);
    send_op(ACT_NONE,  3'd0, 32'sh55555555);
    repeat (4) send_op(ACT_READ, 3'd0, 32'sd0);
    send_op(ACT_READ,  3'd0, 32'sd0);
    send_op(ACT_WRITE, 3'd4, 32'sh12345678);
    send_op(ACT_READ,  3'd5, 32'sd0);
    send_op(ACT_CLEAR, 3'd6, 32'sd0);
    send_op(ACT_NONE,  3'd7, -32'sd1);
    send_op(ACT_WRITE, 3'd1, 32'shAAAAAAAA);
    send_op(ACT_CLEAR, 3'd1, 32'sd0);
    send_op(ACT_READ,  3'd1, 32'sd0);
  endtask

  task automatic test_full_queue();
    for (int i = 0; i < NS - 1; i++) begin
      send_op(ACT_WRITE, 3'd2, (i % 2) ? 32'sh55555555 : 32'shAAAAAAAA);
    end
    send_op(ACT_WRITE, 3'd2, 32'sd7);
    send_op(ACT_WRITE, 3'd2, 32'sd8);
    send_op(ACT_READ,  3'd2, 32'sd0);
    send_op(ACT_WRITE, 3'd2, 32'sd9);
    send_op(ACT_WRITE, 3'd2, 32'sd10);
    send_op(ACT_CLEAR, 3'd2, 32'sd0);
  endtask

  task automatic test_lost_count();
    for (int i = 0; i < NS - 1; i++) send_op(ACT_WRITE, 3'd3, $urandom);
    for (int i = 0; i < LOST_WRITES; i++) send_op(ACT_WRITE, 3'd3, $urandom);
    send_op(ACT_READ,  3'd3, 32'sd0);
    send_op(ACT_WRITE, 3'd3, 32'sd1);
    send_op(ACT_WRITE, 3'd3, 32'sd2);
    send_op(ACT_CLEAR, 3'd3, 32'sd0);
  endtask

  task automatic test_random(input int count, input int write_pct, input int read_pct);
    logic [1:0]         act;
    logic [2:0]         idx;
    logic signed [31:0] data;
    int                 r;
    for (int i = 0; i < count; i++) begin
      idx = ($urandom_range(0, 99) < 8) ? 3'($urandom_range(4, 7))
                                        : 3'($urandom_range(0, NQ - 1));
      r = $urandom_range(0, 99);
      if (r < write_pct) act = ACT_WRITE;
      else if (r < write_pct + read_pct) act = ACT_READ;
      else if (r < write_pct + read_pct + 3) act = ACT_CLEAR;
      else act = ACT_NONE;
      case ($urandom_range(0, 19))
        0: data = 32'sh80000000;
        1: data = 32'sh7FFFFFFF;
        2: data = 32'sd0;
        3: data = -32'sd1;
        default: data = $urandom;
      endcase
      send_op(act, idx, data);
    end
  endtask

  initial begin
    for (int q = 0; q < NQ; q++) begin
      q_head[q]  = 0;
      q_tail[q]  = 0;
      q_count[q] = 0;
      q_lost[q]  = '0;
      for (int s = 0; s < NS; s++) q_slots[q][s] = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    idle_on  = 1'b1;
    stall_on = 1'b1;
    test_basic_ops();
    test_full_queue();
    wait_all_results();

    idle_on  = 1'b0;
    stall_on = 1'b0;
    test_lost_count();
    wait_all_results();

    idle_on  = 1'b1;
    stall_on = 1'b1;
    test_random(380, 70, 25);
    wait_all_results();
    test_random(380, 25, 70);
    test_random(380, 45, 45);
    wait_all_results();

    idle_on  = 1'b0;
    stall_on = 1'b0;
    test_random(380, 45, 45);

    wait_all_results();
    repeat (20) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      err_count++;
    end

    $display("tb_top: %0d items sent, %0d results checked, %0d mismatches",
             items_sent, results_ok, err_count);
    $display("tb_top: %0d full writes, %0d empty reads, %0d bad indexes",
             full_seen, empty_seen, bad_seen);
    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
